// ===== rtl/core/pal_pkg.sv =====
package pal_pkg;

  localparam int OP_W  = 2;
  localparam int POS_W = 9;
  localparam int VAL_W = 32;
  localparam int LEN_W = 9;

  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

endpackage

// ===== rtl/core/pal_ram.sv =====
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/positional_array_list.sv =====
// Steps: write, append, last-entry delete and rejected operations end in the execute
//   state; read adds a read-data state; insert and delete move one entry per cycle
//   through the RAM port pair, and insert then writes the new value in a final state.
// Operations: one at a time; busy drops in the result cycle, so the next
//   transaction can be taken at the edge that ends it. The receiver cannot stall.
// Reset (synchronous, rst_n low) empties the list; stale RAM entries are never read.
module positional_array_list #(
  parameter int CAPACITY     = 256,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pal_pkg::OP_W-1:0]    in_op,
  input  logic [pal_pkg::POS_W-1:0]   in_position,
  input  logic signed [pal_pkg::VAL_W-1:0] in_value,
  output logic                        out_strobe,
  output logic                        out_ok,
  output logic signed [pal_pkg::VAL_W-1:0] out_read_value,
  output logic [pal_pkg::LEN_W-1:0]   out_list_length
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_RDATA = 3'd2;
  localparam logic [2:0] ST_INS   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DEL   = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [pal_pkg::OP_W-1:0]   op_r;
  logic [pal_pkg::POS_W-1:0]  pos_r;
  logic [ELEMENT_BITS-1:0]    val_r, val_in;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;

  logic                       out_strobe_r, out_ok_r;
  logic [pal_pkg::VAL_W-1:0]  out_rd_r, rd_ext;
  logic [pal_pkg::LEN_W-1:0]  out_len_r;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [ELEMENT_BITS-1:0]    ram_wdata, ram_rdata;

  logic                       emit, emit_ok, emit_rd;
  logic                       accept;
  logic [CMP_W-1:0]           pos_c, cnt_c, cnt_m1_c;
  logic [AW-1:0]              pos_a, cnt_m1;
  logic                       rw_ok, ins_ok;

  generate
    if (ELEMENT_BITS <= pal_pkg::VAL_W) begin : g_narrow
      assign val_in = in_value[ELEMENT_BITS-1:0];
      assign rd_ext = pal_pkg::VAL_W'(ram_rdata);
    end else begin : g_wide
      assign val_in = ELEMENT_BITS'(unsigned'(in_value));
      assign rd_ext = ram_rdata[pal_pkg::VAL_W-1:0];
    end
  endgenerate

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign pos_c    = CMP_W'(pos_r);
  assign cnt_c    = CMP_W'(count_r);
  assign cnt_m1_c = cnt_c - CMP_W'(1);
  assign pos_a    = pos_c[AW-1:0];
  assign cnt_m1   = cnt_m1_c[AW-1:0];
  assign rw_ok    = (pos_c < cnt_c);
  assign ins_ok   = (count_r != CNT_W'(CAPACITY)) && (pos_c <= cnt_c);

  pal_ram #(
    .WIDTH(ELEMENT_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r;
    emit      = 1'b0;
    emit_ok   = 1'b0;
    emit_rd   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_r)
          pal_pkg::OP_READ: begin
            if (rw_ok) begin
              ram_raddr = pos_a;
              state_nxt = ST_RDATA;
            end else begin
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          pal_pkg::OP_WRITE: begin
            ram_we    = rw_ok;
            ram_waddr = pos_a;
            ram_wdata = val_r;
            emit      = 1'b1;
            emit_ok   = rw_ok;
            state_nxt = ST_IDLE;
          end
          pal_pkg::OP_INSERT: begin
            if (!ins_ok) begin
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end else if (pos_c == cnt_c) begin
              // append: nothing to move
              ram_we    = 1'b1;
              ram_waddr = pos_a;
              ram_wdata = val_r;
              count_nxt = count_r + CNT_W'(1);
              emit      = 1'b1;
              emit_ok   = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt   = cnt_m1;
              ram_raddr = cnt_m1;
              state_nxt = ST_INS;
            end
          end
          pal_pkg::OP_DELETE: begin
            if (!rw_ok) begin
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end else if (pos_c == cnt_m1_c) begin
              // last entry: only the length shrinks
              count_nxt = count_r - CNT_W'(1);
              emit      = 1'b1;
              emit_ok   = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt   = pos_a + AW'(1);
              ram_raddr = pos_a + AW'(1);
              state_nxt = ST_DEL;
            end
          end
          default: begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RDATA: begin
        emit      = 1'b1;
        emit_ok   = 1'b1;
        emit_rd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_INS: begin
        // move entry idx up one slot, walking down toward the position
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        ram_wdata = ram_rdata;
        if (CMP_W'(idx_r) == pos_c) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          ram_raddr = idx_r - AW'(1);
        end
      end
      ST_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = pos_a;
        ram_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        emit      = 1'b1;
        emit_ok   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DEL: begin
        // move entry idx down one slot, walking up toward the end
        ram_we    = 1'b1;
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
        if (idx_r == cnt_m1) begin
          count_nxt = count_r - CNT_W'(1);
          emit      = 1'b1;
          emit_ok   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_raddr = idx_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      op_r  <= in_op;
      pos_r <= in_position;
      val_r <= val_in;
    end
    if (emit) begin
      out_ok_r  <= emit_ok;
      out_rd_r  <= emit_rd ? rd_ext : '0;
      out_len_r <= pal_pkg::LEN_W'(CMP_W'(count_nxt));
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_ok          = out_ok_r;
  assign out_read_value  = out_rd_r;
  assign out_list_length = out_len_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (state_r == ST_IDLE))
    else $error("result issued while operation still running");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ok) |-> (out_read_value == '0))
    else $error("read data on a rejected operation");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted transaction not executed");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> $past(emit))
    else $error("length changed outside result cycle");
`endif

endmodule
